[design/psp_pkg.sv]
// ----------------------------------------------------------------------------
// psp_pkg
// Types and constants of the point-source phasor predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

  localparam int MAX_CHANNELS = 64;

  typedef struct packed {
    logic signed [15:0] left_re;
    logic signed [15:0] left_im;
    logic signed [15:0] right_re;
    logic signed [15:0] right_im;
    logic signed [15:0] left_step_re;
    logic signed [15:0] left_step_im;
    logic signed [15:0] right_step_re;
    logic signed [15:0] right_step_im;
    logic        [15:0] n_term;
  } psp_in_t;

  typedef struct packed {
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;
    logic        [5:0]  channel;
    logic               last;
  } psp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_BASE,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DIV_END,
    ST_PUSH,
    ST_CHAN
  } psp_state_t;

endpackage

`default_nettype wire

[design/point_source_phasor_predict.sv]
// ----------------------------------------------------------------------------
// point_source_phasor_predict
// Per time sample, predicts one saturated Q1.30 visibility per frequency
// channel from two station phasors, their channel steps and the source n term.
// ----------------------------------------------------------------------------
// One item is worked at a time on a single shared 32x16 multiplier with a
// 49-bit accumulator, plus a one-bit-per-cycle restoring divider for the
// division by n. An item runs through the channel step, the base product
// and the two divisions, then pushes channel 0; each later channel takes
// four multiplies through the shared unit and a push into the output
// register. A push waits while the output register holds an untaken result.
// The last result waits in the output register while the block already
// takes the next item. The user writes num_channels through the cfg port
// only while the block is idle; the block itself does not enforce it.
// 0 counts as 1, values above 64 count as 64.
`default_nettype none

module point_source_phasor_predict
  import psp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire psp_in_t  in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output psp_out_t      out_item,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [6:0] cfg_data
);

  localparam logic signed [48:0] RND_POS = 49'sd16384;
  localparam logic signed [48:0] RND_NEG = 49'sd16383;

  psp_state_t state_r, state_nxt;

  logic [6:0]          num_ch_r;
  psp_in_t             in_r, in_nxt;
  logic [15:0]         n_r, n_nxt;
  logic [5:0]          last_ch_r, last_ch_nxt;
  logic [2:0]          ph_r, ph_nxt;
  logic signed [47:0]  prod_r, prod_nxt;
  logic signed [48:0]  acc_r, acc_nxt;
  logic signed [15:0]  sr_r, sr_nxt, si_r, si_nxt;
  logic signed [32:0]  bre_r, bre_nxt, bim_r, bim_nxt;
  logic                div_im_r, div_im_nxt;
  logic                neg_r, neg_nxt;
  logic [31:0]         dq_r, dq_nxt;
  logic [15:0]         rem_r, rem_nxt;
  logic [4:0]          it_r, it_nxt;
  logic signed [31:0]  vr_r, vr_nxt, vi_r, vi_nxt;
  logic [5:0]          chan_r, chan_nxt;
  psp_out_t            out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  // shared multiplier operands
  logic signed [31:0]  mul_a;
  logic signed [15:0]  mul_b;

  // rounding of the accumulator by 2^15, half away from zero
  logic signed [48:0]  rnd_sum;
  logic signed [33:0]  rnd_q;
  logic signed [15:0]  rnd_sat16;
  logic signed [31:0]  rnd_sat32;

  // divider datapath
  logic signed [32:0]  div_x;
  logic [31:0]         div_mag;
  logic [16:0]         rem_sh;
  logic                rem_ge;
  logic signed [31:0]  div_val;

  logic                do_sub;
  logic                push_ok;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // operand select for the four products of each complex multiply
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_STEP: begin
        case (ph_r)
          3'd0: begin
            mul_a = 32'(in_r.right_step_re); mul_b = in_r.left_step_re;
          end
          3'd1: begin
            mul_a = 32'(in_r.right_step_im); mul_b = in_r.left_step_im;
          end
          3'd2: begin
            mul_a = 32'(in_r.right_step_im); mul_b = in_r.left_step_re;
          end
          3'd3: begin
            mul_a = 32'(in_r.right_step_re); mul_b = in_r.left_step_im;
          end
          default: ;
        endcase
      end
      ST_BASE: begin
        case (ph_r)
          3'd0: begin mul_a = 32'(in_r.right_re); mul_b = in_r.left_re; end
          3'd1: begin mul_a = 32'(in_r.right_im); mul_b = in_r.left_im; end
          3'd2: begin mul_a = 32'(in_r.right_im); mul_b = in_r.left_re; end
          3'd3: begin mul_a = 32'(in_r.right_re); mul_b = in_r.left_im; end
          default: ;
        endcase
      end
      ST_CHAN: begin
        case (ph_r)
          3'd0: begin mul_a = vr_r; mul_b = sr_r; end
          3'd1: begin mul_a = vi_r; mul_b = si_r; end
          3'd2: begin mul_a = vr_r; mul_b = si_r; end
          3'd3: begin mul_a = vi_r; mul_b = sr_r; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  assign rnd_sum = acc_r + (acc_r[48] ? RND_NEG : RND_POS);
  assign rnd_q   = rnd_sum[48:15];

  always_comb begin
    if (!rnd_q[33] && (|rnd_q[32:15])) begin
      rnd_sat16 = 16'sh7fff;
    end else if (rnd_q[33] && !(&rnd_q[32:15])) begin
      rnd_sat16 = -16'sh8000;
    end else begin
      rnd_sat16 = rnd_q[15:0];
    end
    if (!rnd_q[33] && (|rnd_q[32:31])) begin
      rnd_sat32 = 32'sh7fffffff;
    end else if (rnd_q[33] && !(&rnd_q[32:31])) begin
      rnd_sat32 = 32'sh80000000;
    end else begin
      rnd_sat32 = rnd_q[31:0];
    end
  end

  assign div_x   = div_im_r ? bim_r : bre_r;
  assign div_mag = div_x[32] ? 32'(-div_x) : 32'(div_x);
  assign rem_sh  = {rem_r, dq_r[31]};
  assign rem_ge  = (rem_sh >= {1'b0, n_r});

  // quotient magnitude never exceeds 2^31, so the negated form always fits
  always_comb begin
    if (neg_r) begin
      div_val = 32'sd0 - $signed(dq_r);
    end else if (dq_r[31]) begin
      div_val = 32'sh7fffffff;
    end else begin
      div_val = $signed(dq_r);
    end
  end

  // first sum of a product pair adds for step and base, subtracts for channels
  assign do_sub  = (ph_r == 3'd2) == (state_r == ST_CHAN);
  assign push_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    n_nxt         = n_r;
    last_ch_nxt   = last_ch_r;
    ph_nxt        = ph_r;
    acc_nxt       = acc_r;
    sr_nxt        = sr_r;
    si_nxt        = si_r;
    bre_nxt       = bre_r;
    bim_nxt       = bim_r;
    div_im_nxt    = div_im_r;
    neg_nxt       = neg_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    it_nxt        = it_r;
    vr_nxt        = vr_r;
    vi_nxt        = vi_r;
    chan_nxt      = chan_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    // product pair accumulation, shared by the three multiply states
    if (state_r == ST_STEP || state_r == ST_BASE || state_r == ST_CHAN) begin
      case (ph_r)
        3'd1, 3'd3: acc_nxt = 49'(prod_r);
        3'd2, 3'd4: acc_nxt = do_sub ? acc_r - 49'(prod_r) : acc_r + 49'(prod_r);
        default: ;
      endcase
      ph_nxt = ph_r + 3'd1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt = in_item;
          n_nxt  = (in_item.n_term == 16'd0) ? 16'd1 : in_item.n_term;
          if (num_ch_r == 7'd0) begin
            last_ch_nxt = 6'd0;
          end else if (num_ch_r > 7'(MAX_CHANNELS)) begin
            last_ch_nxt = 6'(MAX_CHANNELS - 1);
          end else begin
            last_ch_nxt = 6'(num_ch_r - 7'd1);
          end
          ph_nxt    = 3'd0;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (ph_r == 3'd3) sr_nxt = rnd_sat16;
        if (ph_r == 3'd5) begin
          si_nxt    = rnd_sat16;
          ph_nxt    = 3'd0;
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        if (ph_r == 3'd3) bre_nxt = acc_r[32:0];
        if (ph_r == 3'd5) begin
          bim_nxt    = acc_r[32:0];
          div_im_nxt = 1'b0;
          state_nxt  = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        // pre-add half the divisor for rounding half away from zero
        neg_nxt   = div_x[32];
        dq_nxt    = div_mag + 32'(n_r[15:1]);
        rem_nxt   = '0;
        it_nxt    = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? 16'(rem_sh - {1'b0, n_r}) : rem_sh[15:0];
        dq_nxt  = {dq_r[30:0], rem_ge};
        it_nxt  = it_r + 5'd1;
        if (it_r == 5'd31) state_nxt = ST_DIV_END;
      end
      ST_DIV_END: begin
        if (!div_im_r) begin
          vr_nxt     = div_val;
          div_im_nxt = 1'b1;
          state_nxt  = ST_DIV_LOAD;
        end else begin
          vi_nxt    = div_val;
          chan_nxt  = 6'd0;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ok) begin
          out_valid_nxt    = 1'b1;
          out_nxt.value_re = vr_r;
          out_nxt.value_im = vi_r;
          out_nxt.channel  = chan_r;
          out_nxt.last     = (chan_r == last_ch_r);
          if (chan_r == last_ch_r) begin
            state_nxt = ST_IDLE;
          end else begin
            chan_nxt  = chan_r + 6'd1;
            ph_nxt    = 3'd0;
            state_nxt = ST_CHAN;
          end
        end
      end
      ST_CHAN: begin
        // vr is rewritten only after its last use in this pass
        if (ph_r == 3'd3) vr_nxt = rnd_sat32;
        if (ph_r == 3'd5) begin
          vi_nxt    = rnd_sat32;
          state_nxt = ST_PUSH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      num_ch_r    <= 7'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) num_ch_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    n_r       <= n_nxt;
    last_ch_r <= last_ch_nxt;
    ph_r      <= ph_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    sr_r      <= sr_nxt;
    si_r      <= si_nxt;
    bre_r     <= bre_nxt;
    bim_r     <= bim_nxt;
    div_im_r  <= div_im_nxt;
    neg_r     <= neg_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    it_r      <= it_nxt;
    vr_r      <= vr_nxt;
    vi_r      <= vi_nxt;
    chan_r    <= chan_nxt;
    out_r     <= out_nxt;
  end

endmodule

`default_nettype wire
